// ----- rtl/core/kdtree_radius_search_next_macros.svh -----
// assertion macros for the kd-tree radius search block
`ifndef KDTREE_RADIUS_SEARCH_NEXT_MACROS_SVH
`define KDTREE_RADIUS_SEARCH_NEXT_MACROS_SVH
`ifndef ASSERT_OFF
`define KRS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define KRS_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define KRS_ASSERT(label, clk, rst_n, prop, msg)
`define KRS_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

// ----- rtl/core/krs_pkg.sv -----
// ----------------------------------------------------------------------------
// krs_pkg
// shared types and constants for the kd-tree radius search block
// ----------------------------------------------------------------------------
package krs_pkg;
  localparam int unsigned MaxPoints  = 1024;
  localparam int unsigned MaxDims    = 4;
  localparam int unsigned StackDepth = 64;

  localparam logic [2:0] KindLoadCoord = 3'd0;
  localparam logic [2:0] KindLoadNode  = 3'd1;
  localparam logic [2:0] KindSetRoot   = 3'd2;
  localparam logic [2:0] KindSetQuery  = 3'd3;
  localparam logic [2:0] KindSearch    = 3'd4;

  localparam logic [0:0] RegRadius = 1'd0;
  localparam logic [0:0] RegDims   = 1'd1;

  typedef enum logic [2:0] {
    StIdle,
    StPop,
    StRead,
    StEval,
    StPush,
    StDone
  } state_e;
endpackage

// ----- rtl/core/kdtree_radius_search_next.sv -----
// ----------------------------------------------------------------------------
// kdtree_radius_search_next
// fixed-radius kd-tree search with an explicit walk stack held in memories
// sequence: a load or set item answers in the cycle after it is accepted; a search
// item steps each popped node through pop, memory read, evaluate and near then far
// push states; it ends in pop when the stack empties or the walk is abandoned, or after a match
// throughput: one item at a time; the node loop through the memories sets it
// reset: dims set to 1; control, radius, root, query and stack pointer cleared
// ----------------------------------------------------------------------------
`include "kdtree_radius_search_next_macros.svh"
module kdtree_radius_search_next #(
  parameter int unsigned MAX_POINTS  = krs_pkg::MaxPoints,
  parameter int unsigned MAX_DIMS    = krs_pkg::MaxDims,
  parameter int unsigned STACK_DEPTH = krs_pkg::StackDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         kind_i,
  input  logic [9:0]         point_index_i,
  input  logic [1:0]         axis_i,
  input  logic signed [15:0] coord_i,
  input  logic [9:0]         split_depth_i,
  input  logic signed [10:0] left_child_i,
  input  logic signed [10:0] right_child_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               found_o,
  output logic [9:0]         match_index_o,
  output logic               stack_overflow_o
);
  localparam int unsigned PW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int unsigned SW = $clog2(STACK_DEPTH);
  localparam int unsigned TW = SW + 1;
  localparam int unsigned CW = PW + 1;

  // configuration registers
  logic [16:0] radius_q;
  logic [2:0]  dims_q;
  logic        cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= '0;
      dims_q   <= 3'd1;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        krs_pkg::RegRadius: radius_q <= pwdata[16:0];
        krs_pkg::RegDims:   dims_q   <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      krs_pkg::RegRadius: prdata = {15'd0, radius_q};
      krs_pkg::RegDims:   prdata = {29'd0, dims_q};
      default: ;
    endcase
  end

  // effective dimension count, clamped to 1..MAX_DIMS
  logic [3:0] dims_eff;
  always_comb begin
    if (dims_q == 3'd0) dims_eff = 4'd1;
    else if (32'(dims_q) > MAX_DIMS) dims_eff = 4'(MAX_DIMS);
    else dims_eff = {1'b0, dims_q};
  end

  // depth mod dims for dims 1..8: masks for powers of two, digit sums for
  // 3, 5 and 7 (4, 16 and 8 each leave 1), and 6 from the mod 3 and parity
  function automatic logic [2:0] depth_mod(logic [9:0] x, logic [3:0] m);
    logic [3:0] s3;
    logic [2:0] t3;
    logic [2:0] r3;
    logic [5:0] s5;
    logic [4:0] t5;
    logic [4:0] s7;
    logic [3:0] t7;
    logic [2:0] r;
    s3 = 4'(x[1:0]) + 4'(x[3:2]) + 4'(x[5:4]) + 4'(x[7:6]) + 4'(x[9:8]);
    t3 = 3'(s3[1:0]) + 3'(s3[3:2]);
    if (t3 >= 3'd3) t3 = t3 - 3'd3;
    if (t3 >= 3'd3) t3 = t3 - 3'd3;
    r3 = t3;
    s5 = 6'(x[3:0]) + 6'(x[7:4]) + 6'(x[9:8]);
    t5 = 5'(s5[3:0]) + 5'(s5[5:4]);
    if (t5 >= 5'd5) t5 = t5 - 5'd5;
    if (t5 >= 5'd5) t5 = t5 - 5'd5;
    if (t5 >= 5'd5) t5 = t5 - 5'd5;
    s7 = 5'(x[2:0]) + 5'(x[5:3]) + 5'(x[8:6]) + 5'(x[9]);
    t7 = 4'(s7[2:0]) + 4'(s7[4:3]);
    if (t7 >= 4'd7) t7 = t7 - 4'd7;
    case (m)
      4'd3: r = r3;
      4'd5: r = 3'(t5);
      4'd6: r = (r3[0] == x[0]) ? r3 : r3 + 3'd3;
      4'd7: r = 3'(t7);
      default: r = 3'(x & 10'(m - 4'd1));
    endcase
    return r;
  endfunction

  // memories: each point row holds all coordinates so one read gives them
  logic [MAX_DIMS*16-1:0] pt_mem [MAX_POINTS];
  logic [31:0]            nd_mem [MAX_POINTS];
  logic [PW-1:0]          stk_mem [STACK_DEPTH];
  logic [MAX_DIMS*16-1:0] pt_rd_q;
  logic [31:0]            nd_rd_q;
  logic [PW-1:0]          stk_rd_q;

  logic [PW-1:0]           root_q;
  logic signed [15:0]      query_q [MAX_DIMS];
  logic [TW-1:0]           top_q, top_d;
  krs_pkg::state_e         state_q, state_d;
  logic [PW-1:0]           node_q;
  logic [CW:0]             pops_q, pops_d;
  logic                    found_q, found_d, ovf_q, ovf_d;
  logic [9:0]              match_q, match_d;
  logic [PW-1:0]           push_a_q, push_b_q;
  logic                    push_a_ok_q, push_b_ok_q;

  // distance and plane offset terms from the node read, valid in eval
  logic [34:0]        dist_q;
  logic [35:0]        dsum;
  logic signed [16:0] off_c;
  logic [9:0]         ndepth;
  logic [DW-1:0]      split_ax;

  assign ndepth   = nd_rd_q[31:22];
  assign split_ax = DW'(depth_mod(ndepth, dims_eff));

  always_comb begin
    logic signed [16:0] df;
    dsum = '0;
    for (int d = 0; d < MAX_DIMS; d++) begin
      df = 17'(query_q[d]) - 17'($signed(pt_rd_q[d*16 +: 16]));
      if (d < 32'(dims_eff)) dsum = dsum + 36'(34'($signed(df) * $signed(df)));
    end
    off_c = 17'(query_q[split_ax]) - 17'($signed(pt_rd_q[split_ax*16 +: 16]));
  end

  logic signed [10:0] lc_c, rc_c;
  logic               lc_ok, rc_ok;
  logic [16:0]        aoff;
  assign lc_c  = nd_rd_q[21:11];
  assign rc_c  = nd_rd_q[10:0];
  assign lc_ok = !lc_c[10] && (32'(lc_c) < MAX_POINTS);
  assign rc_ok = !rc_c[10] && (32'(rc_c) < MAX_POINTS);
  assign aoff  = off_c[16] ? 17'(-off_c) : 17'(off_c);

  logic [33:0] r2;
  assign r2 = 34'(radius_q * radius_q);

  // stack memory port signals
  logic          stk_we;
  logic [SW-1:0] stk_wa;
  logic [PW-1:0] stk_wd;
  logic [SW-1:0] stk_ra;
  logic          push_first_q;

  // read the entry under the next stack pointer, forwarding a same-cycle push
  assign stk_ra = SW'(top_d - 1'b1);

  logic in_fire;
  assign in_ready_o = (state_q == krs_pkg::StIdle);
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i) begin
    if (in_fire && kind_i == krs_pkg::KindLoadCoord && 32'(point_index_i) < MAX_POINTS
        && 32'(axis_i) < MAX_DIMS)
      pt_mem[PW'(point_index_i)][DW'(axis_i)*16 +: 16] <= coord_i;
    if (in_fire && kind_i == krs_pkg::KindLoadNode && 32'(point_index_i) < MAX_POINTS)
      nd_mem[PW'(point_index_i)] <= {split_depth_i, left_child_i, right_child_i};
    pt_rd_q <= pt_mem[node_q];
    nd_rd_q <= nd_mem[node_q];
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    if (stk_we && stk_wa == stk_ra) stk_rd_q <= stk_wd;
    else stk_rd_q <= stk_mem[stk_ra];
  end

  // stack writes: push state writes near then far entry; idle writes the root for a search on an empty stack
  always_comb begin
    stk_we = 1'b0;
    stk_wa = SW'(top_q);
    stk_wd = push_first_q ? push_a_q : push_b_q;
    if (state_q == krs_pkg::StPush) begin
      stk_we = (push_first_q ? push_a_ok_q : push_b_ok_q) && (32'(top_q) < STACK_DEPTH);
    end
    if (state_q == krs_pkg::StIdle && in_fire && kind_i == krs_pkg::KindSearch
        && top_q == '0) begin
      stk_we = 1'b1;
      stk_wa = '0;
      stk_wd = root_q;
    end
  end

  always_comb begin
    state_d = state_q;
    top_d   = top_q;
    pops_d  = pops_q;
    found_d = found_q;
    ovf_d   = ovf_q;
    match_d = match_q;
    unique case (state_q)
      krs_pkg::StIdle: begin
        if (in_fire) begin
          found_d = 1'b0;
          ovf_d   = 1'b0;
          match_d = '0;
          pops_d  = '0;
          state_d = krs_pkg::StDone;
          if (kind_i == krs_pkg::KindSetQuery && 32'(axis_i) < MAX_DIMS) top_d = '0;
          if (kind_i == krs_pkg::KindSearch) begin
            state_d = krs_pkg::StPop;
            if (top_q == '0) top_d = TW'(1);
          end
        end
      end
      krs_pkg::StPop: begin
        // stack read data for top-1 is valid here
        if (top_q == '0) state_d = krs_pkg::StDone;
        else if (32'(pops_q) >= MAX_POINTS) begin
          top_d   = '0;
          state_d = krs_pkg::StDone;
        end else begin
          pops_d  = pops_q + 1'b1;
          top_d   = top_q - 1'b1;
          state_d = krs_pkg::StRead;
        end
      end
      krs_pkg::StRead: state_d = krs_pkg::StEval;
      krs_pkg::StEval: state_d = krs_pkg::StPush;
      krs_pkg::StPush: begin
        if (push_first_q ? push_a_ok_q : push_b_ok_q) begin
          if (32'(top_q) < STACK_DEPTH) top_d = top_q + 1'b1;
          else ovf_d = 1'b1;
        end
        if (!push_first_q) begin
          if (dist_q <= 35'(r2)) begin
            found_d = 1'b1;
            match_d = 10'(node_q);
            state_d = krs_pkg::StDone;
          end else begin
            state_d = krs_pkg::StPop;
          end
        end
      end
      krs_pkg::StDone: if (out_ready_i) state_d = krs_pkg::StIdle;
      default: state_d = krs_pkg::StIdle;
    endcase
  end

  logic pop_go;
  assign pop_go = state_q == krs_pkg::StPop && top_q != '0 && 32'(pops_q) < MAX_POINTS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= krs_pkg::StIdle;
      top_q        <= '0;
      root_q       <= '0;
      pops_q       <= '0;
      found_q      <= 1'b0;
      ovf_q        <= 1'b0;
      match_q      <= '0;
      push_first_q <= 1'b0;
      node_q       <= '0;
      for (int d = 0; d < MAX_DIMS; d++) query_q[d] <= '0;
    end else begin
      state_q <= state_d;
      top_q   <= top_d;
      pops_q  <= pops_d;
      found_q <= found_d;
      ovf_q   <= ovf_d;
      match_q <= match_d;
      if (in_fire && kind_i == krs_pkg::KindSetRoot && 32'(point_index_i) < MAX_POINTS)
        root_q <= PW'(point_index_i);
      if (in_fire && kind_i == krs_pkg::KindSetQuery && 32'(axis_i) < MAX_DIMS)
        query_q[DW'(axis_i)] <= coord_i;
      if (pop_go) node_q <= stk_rd_q;
      if (state_q == krs_pkg::StEval) push_first_q <= 1'b1;
      else if (state_q == krs_pkg::StPush) push_first_q <= 1'b0;
    end
  end

  // datapath registers: distance and push candidates captured in eval
  always_ff @(posedge clk_i) begin
    if (state_q == krs_pkg::StEval) begin
      dist_q <= 35'(dsum);
      if (off_c > 0) begin
        push_a_q    <= PW'(rc_c);
        push_a_ok_q <= rc_ok;
        push_b_q    <= PW'(lc_c);
        push_b_ok_q <= lc_ok && (aoff <= radius_q);
      end else begin
        push_a_q    <= PW'(lc_c);
        push_a_ok_q <= lc_ok;
        push_b_q    <= PW'(rc_c);
        push_b_ok_q <= rc_ok && (aoff <= radius_q);
      end
    end
  end

  assign out_valid_o      = (state_q == krs_pkg::StDone);
  assign found_o          = found_q;
  assign match_index_o    = found_q ? match_q : 10'd0;
  assign stack_overflow_o = ovf_q;

  `KRS_ASSERT(a_stack_bound, clk_i, rst_ni, 32'(top_q) <= STACK_DEPTH, "stack pointer past depth")
  `KRS_ASSERT(a_match_found, clk_i, rst_ni, out_valid_o && !found_o |-> match_index_o == 10'd0, "match without found")
  `KRS_ASSERT(a_busy_no_ready, clk_i, rst_ni, (state_q != krs_pkg::StIdle) |-> !in_ready_o, "ready while busy")
endmodule

// ----- verif/kdtree_radius_search_next_tb.sv -----
// ----------------------------------------------------------------------------
// kdtree_radius_search_next_tb
// self-checking bench for the kd-tree radius search block: loads small trees
// with random points, walks them with search-next items under random radius
// and dimension settings, and checks every result against an in-bench walk
// ----------------------------------------------------------------------------
module kdtree_radius_search_next_tb;

  localparam int unsigned CycleLimit = 50_000_000;
  localparam logic [2:0]  AddrRadius = 3'(4 * krs_pkg::RegRadius);
  localparam logic [2:0]  AddrDims   = 3'(4 * krs_pkg::RegDims);

  typedef struct packed {
    logic [2:0]         kind;
    logic [9:0]         idx;
    logic [1:0]         axis;
    logic signed [15:0] coord;
    logic [9:0]         sdepth;
    logic signed [10:0] lc;
    logic signed [10:0] rc;
  } item_t;

  typedef struct packed {
    logic       found;
    logic [9:0] match;
    logic       ovf;
  } hit_t;

  logic               clk_i, rst_ni;
  logic               psel, penable, pwrite, pready;
  logic [2:0]         paddr;
  logic [31:0]        pwdata, prdata;
  logic               in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic [2:0]         kind_i;
  logic [9:0]         point_index_i, split_depth_i, match_index_o;
  logic [1:0]         axis_i;
  logic signed [15:0] coord_i;
  logic signed [10:0] left_child_i, right_child_i;
  logic               found_o, stack_overflow_o;

  kdtree_radius_search_next DUT (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o, .kind_i, .point_index_i, .axis_i, .coord_i,
    .split_depth_i, .left_child_i, .right_child_i,
    .out_valid_o, .out_ready_i, .found_o, .match_index_o, .stack_overflow_o
  );

  // mirror of the block state
  int   pt_coord [krs_pkg::MaxPoints][krs_pkg::MaxDims];
  int   nd_depth [krs_pkg::MaxPoints];
  int   nd_left  [krs_pkg::MaxPoints];
  int   nd_right [krs_pkg::MaxPoints];
  int   root_id;
  int   query    [krs_pkg::MaxDims];
  int   walk_stk [krs_pkg::StackDepth];
  int   walk_sp;
  int   radius_r;
  int   dims_r;

  hit_t expected_hits [$];
  int   errors;
  int   cycles;
  int   burst_left;

  // ids of the current tree, all of them fully loaded
  int   tree_ids [$];

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // timeout guard
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("kdtree_radius_search_next: mismatch");
      $finish;
    end
  end

  // receiver stall pattern: a randomly redrawn mode holds ready high, random or high a quarter of the time
  int rx_mode;
  always @(posedge clk_i) begin
    if (cycles % 256 == 0) rx_mode = $urandom_range(0, 2);
    case (rx_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= 1'($urandom_range(0, 1));
      default: out_ready_i <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // result checker: oldest expectation against each accepted result
  always @(posedge clk_i) begin
    hit_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_hits.size() == 0) begin
        $display("%0t: result with nothing expected found=%0b idx=%0d ovf=%0b",
                 $time, found_o, match_index_o, stack_overflow_o);
        errors++;
      end else begin
        want = expected_hits.pop_front();
        if (found_o !== want.found) begin
          $display("%0t: found exp %0b got %0b", $time, want.found, found_o);
          errors++;
        end
        if (match_index_o !== want.match) begin
          $display("%0t: match_index exp %0d got %0d", $time, want.match, match_index_o);
          errors++;
        end
        if (stack_overflow_o !== want.ovf) begin
          $display("%0t: stack_overflow exp %0b got %0b", $time, want.ovf, stack_overflow_o);
          errors++;
        end
      end
    end
  end

  function automatic void push_node(int n, inout bit ovf);
    if (walk_sp >= krs_pkg::StackDepth) ovf = 1'b1;
    else begin
      walk_stk[walk_sp] = n;
      walk_sp++;
    end
  endfunction

  function automatic bit child_valid(int c);
    return c >= 0 && c < krs_pkg::MaxPoints;
  endfunction

  // resume the depth-first walk until a point inside the ball turns up or the stack empties
  function automatic hit_t walk_search();
    hit_t   h;
    int     dims, pops, n, d, l, r;
    longint r2, off, aoff, ds, df;
    bit     ovf;
    dims = (dims_r == 0) ? 1 : (dims_r > krs_pkg::MaxDims) ? krs_pkg::MaxDims : dims_r;
    r2   = longint'(radius_r) * longint'(radius_r);
    h    = '0;
    ovf  = 1'b0;
    pops = 0;
    if (walk_sp == 0) push_node(root_id, ovf);
    while (walk_sp > 0 && !h.found) begin
      // runaway walk gives up and empties the stack
      if (pops >= krs_pkg::MaxPoints) begin
        walk_sp = 0;
        break;
      end
      pops++;
      walk_sp--;
      n  = walk_stk[walk_sp];
      l  = nd_left[n];
      r  = nd_right[n];
      d  = nd_depth[n] % dims;
      ds = 0;
      for (int k = 0; k < dims; k++) begin
        df = longint'(query[k]) - longint'(pt_coord[n][k]);
        ds += df * df;
      end
      if (ds <= r2) begin
        h.found = 1'b1;
        h.match = 10'(n);
      end
      off  = longint'(query[d]) - longint'(pt_coord[n][d]);
      aoff = off < 0 ? -off : off;
      // near child pushed first, far child only within the radius; zero offset goes left
      if (off > 0) begin
        if (child_valid(r)) push_node(r, ovf);
        if (child_valid(l) && aoff <= radius_r) push_node(l, ovf);
      end else begin
        if (child_valid(l)) push_node(l, ovf);
        if (child_valid(r) && aoff <= radius_r) push_node(r, ovf);
      end
    end
    h.ovf = ovf;
    return h;
  endfunction

  // update the mirror for one accepted item and queue its expected result
  function automatic void apply_item(item_t it);
    hit_t h;
    h = '0;
    case (it.kind)
      krs_pkg::KindLoadCoord: pt_coord[it.idx][it.axis] = int'(it.coord);
      krs_pkg::KindLoadNode: begin
        nd_depth[it.idx] = int'(it.sdepth);
        nd_left[it.idx]  = int'(it.lc);
        nd_right[it.idx] = int'(it.rc);
      end
      krs_pkg::KindSetRoot: root_id = int'(it.idx);
      krs_pkg::KindSetQuery: begin
        query[it.axis] = int'(it.coord);
        walk_sp = 0;
      end
      krs_pkg::KindSearch: h = walk_search();
      default: ;
    endcase
    expected_hits.push_back(h);
  endfunction

  // random filler for the fields an item does not use
  function automatic item_t noise_item(logic [2:0] kind);
    item_t it;
    it.kind   = kind;
    it.idx    = 10'($urandom);
    it.axis   = 2'($urandom);
    it.coord  = 16'($urandom);
    it.sdepth = 10'($urandom);
    it.lc     = 11'($urandom);
    it.rc     = 11'($urandom);
    return it;
  endfunction

  // one item over the valid/ready channel, with bursts and gaps
  task automatic send_item(item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i    <= 1'b1;
    kind_i        <= it.kind;
    point_index_i <= it.idx;
    axis_i        <= it.axis;
    coord_i       <= it.coord;
    split_depth_i <= it.sdepth;
    left_child_i  <= it.lc;
    right_child_i <= it.rc;
    do @(posedge clk_i); while (!in_ready_o);
    apply_item(it);
  endtask

  // drain everything in flight, then a few spare cycles
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (expected_hits.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == AddrRadius) radius_r = int'(data[16:0]);
    else dims_r = int'(data[2:0]);
  endtask

  task automatic configure(int rad, int dims);
    wait_idle();
    reg_write(AddrRadius, 32'(rad));
    reg_write(AddrDims, 32'(dims));
  endtask

  task automatic load_point(int id, int c0, int c1, int c2, int c3);
    item_t it;
    int    c [krs_pkg::MaxDims];
    c = '{c0, c1, c2, c3};
    for (int a = 0; a < krs_pkg::MaxDims; a++) begin
      it       = noise_item(krs_pkg::KindLoadCoord);
      it.idx   = 10'(id);
      it.axis  = 2'(a);
      it.coord = 16'(c[a]);
      send_item(it);
    end
  endtask

  task automatic load_node(int id, int depth, int l, int r);
    item_t it;
    it        = noise_item(krs_pkg::KindLoadNode);
    it.idx    = 10'(id);
    it.sdepth = 10'(depth);
    it.lc     = 11'(l);
    it.rc     = 11'(r);
    send_item(it);
  endtask

  task automatic set_root(int id);
    item_t it;
    it     = noise_item(krs_pkg::KindSetRoot);
    it.idx = 10'(id);
    send_item(it);
  endtask

  task automatic set_query(int axis, int value);
    item_t it;
    it       = noise_item(krs_pkg::KindSetQuery);
    it.axis  = 2'(axis);
    it.coord = 16'(value);
    send_item(it);
  endtask

  task automatic search_next();
    send_item(noise_item(krs_pkg::KindSearch));
  endtask

  // two-node tree at the coordinate extremes, exact and huge radius,
  // zero plane offset, missing children and unknown kinds
  task automatic test_directed();
    configure(0, 2);
    load_point(1023, 32767, -32768, 32767, -32768);
    load_point(0, 0, 0, -32768, 32767);
    load_node(1023, 0, 0, -1);
    load_node(0, 1023, -1024, -1);
    set_root(1023);
    set_query(0, 0);
    search_next();          // node 0 matches exactly: zero offset on axis 1
    search_next();          // stack empty, restart at root
    send_item(noise_item(3'd5));
    send_item(noise_item(3'd7));
    set_query(0, 32767);
    set_query(1, -32768);
    search_next();          // radius zero hits node 1023 exactly
    search_next();
    configure(131071, 4);
    search_next();
    search_next();
  endtask

  // a node that is its own two children: the stack fills and the walk runs away
  task automatic test_stack_overflow();
    configure(10, 2);
    load_point(77, 10, 10, 0, 0);
    load_node(77, 0, 77, 77);
    set_root(77);
    set_query(0, 0);
    set_query(1, 0);
    search_next();
    search_next();
  endtask

  function automatic int clamp16(int v);
    return v > 32767 ? 32767 : v < -32768 ? -32768 : v;
  endfunction

  // random trees, settings and item mixes, phase after phase
  task automatic test_random_walks();
    int sent, spread, n, lc, rc, base, pick;
    bit cyclic;
    bit used [krs_pkg::MaxPoints];
    sent = 0;
    while (sent < 1900) begin
      spread = ($urandom_range(0, 2) == 0) ? 32767 : $urandom_range(8, 2000);
      case ($urandom_range(0, 5))
        0:       configure(0, $urandom_range(0, 7));
        1:       configure(131071, $urandom_range(0, 7));
        2:       configure($urandom_range(0, spread / 8), $urandom_range(0, 7));
        default: configure($urandom_range(0, spread), $urandom_range(0, 7));
      endcase
      cyclic = ($urandom_range(0, 7) == 0);
      n      = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(2, 16);
      tree_ids.delete();
      foreach (used[i]) used[i] = 1'b0;
      while (tree_ids.size() < n) begin
        pick = $urandom_range(0, krs_pkg::MaxPoints - 1);
        if (!used[pick]) begin
          used[pick] = 1'b1;
          tree_ids.push_back(pick);
        end
      end
      // every point gets all axes before any node refers to it
      foreach (tree_ids[p]) begin
        load_point(tree_ids[p],
                   $urandom_range(0, 2 * spread) - spread,
                   $urandom_range(0, 2 * spread) - spread,
                   $urandom_range(0, 2 * spread) - spread,
                   $urandom_range(0, 2 * spread) - spread);
        sent += 4;
      end
      foreach (tree_ids[p]) begin
        lc = -1;
        rc = -1;
        if (cyclic) begin
          if ($urandom_range(0, 2) != 0) lc = tree_ids[$urandom_range(0, n - 1)];
          if ($urandom_range(0, 2) != 0) rc = tree_ids[$urandom_range(0, n - 1)];
        end else begin
          if (p + 1 < n && $urandom_range(0, 3) != 0)
            lc = tree_ids[$urandom_range(p + 1, n - 1)];
          if (p + 1 < n && $urandom_range(0, 3) != 0)
            rc = tree_ids[$urandom_range(p + 1, n - 1)];
        end
        // other negatives also mean no child
        if (lc < 0 && $urandom_range(0, 3) == 0) lc = -$urandom_range(2, 1024);
        if (rc < 0 && $urandom_range(0, 3) == 0) rc = -$urandom_range(2, 1024);
        load_node(tree_ids[p], $urandom_range(0, 1023), lc, rc);
        sent++;
      end
      set_root(tree_ids[0]);
      for (int a = 0; a < krs_pkg::MaxDims; a++) begin
        set_query(a, $urandom_range(0, 2 * spread) - spread);
      end
      sent += 5;
      repeat ($urandom_range(60, 120)) begin
        pick = $urandom_range(0, 99);
        if (pick < 50) search_next();
        else if (pick < 65) begin
          // query near a stored point so the ball holds something
          base = tree_ids[$urandom_range(0, n - 1)];
          set_query($urandom_range(0, krs_pkg::MaxDims - 1),
                    clamp16(pt_coord[base][$urandom_range(0, krs_pkg::MaxDims - 1)] +
                            $urandom_range(0, spread / 2) - spread / 4));
        end else if (pick < 75) set_root(tree_ids[$urandom_range(0, n - 1)]);
        else if (pick < 85) send_item(noise_item(3'($urandom_range(5, 7))));
        else if (pick < 95) begin
          item_t it;
          it       = noise_item(krs_pkg::KindLoadCoord);
          it.idx   = 10'(tree_ids[$urandom_range(0, n - 1)]);
          it.coord = 16'(clamp16($urandom_range(0, 2 * spread) - spread));
          send_item(it);
        end else begin
          // relink a node, keeping the tree shape of this phase
          base = $urandom_range(0, n - 1);
          lc = (cyclic || base + 1 < n) ?
               tree_ids[cyclic ? $urandom_range(0, n - 1) :
                                 $urandom_range(base + 1, n - 1)] : -1;
          load_node(tree_ids[base], $urandom_range(0, 1023), lc, -1);
        end
        sent++;
      end
    end
  endtask

  initial begin
    errors     = 0;
    cycles     = 0;
    burst_left = 0;
    rx_mode    = 0;
    rst_ni        <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    in_valid_i    <= 1'b0;
    kind_i        <= '0;
    point_index_i <= '0;
    axis_i        <= '0;
    coord_i       <= '0;
    split_depth_i <= '0;
    left_child_i  <= '0;
    right_child_i <= '0;
    out_ready_i   <= 1'b0;
    // state after reset
    radius_r = 0;
    dims_r   = 1;
    root_id  = 0;
    walk_sp  = 0;
    foreach (query[a]) query[a] = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_stack_overflow();
    test_random_walks();

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (errors == 0 && expected_hits.size() == 0) begin
      $display("kdtree_radius_search_next: match");
    end else begin
      $display("kdtree_radius_search_next: mismatch");
    end
    $finish;
  end
endmodule
